// ===== hw/rtl/md5de_pkg.sv =====
// MD5 digest engine package: transaction types, round constants and
// per-round index functions. No dependencies.
package md5de_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       carries_byte;
		logic       message_end;
	} md5de_in_t;

	typedef struct packed {
		logic [7:0] digest_byte;
		logic       digest_last;
	} md5de_out_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} md5de_work_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FIN,
		ST_OUT
	} md5de_state_t;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;
	localparam logic [7:0]  PAD_MARK = 8'h80;
	localparam logic [5:0]  LAST_POS = 6'h3f;
	localparam logic [5:0]  LAST_RND = 6'h3f;
	localparam logic [3:0]  LAST_OUT = 4'hf;

	function automatic logic [31:0] round_k(input logic [5:0] r);
		logic [31:0] k;
		case (r)
			6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] round_s(input logic [5:0] r);
		logic [4:0] s;
		case ({r[5:4], r[1:0]})
			4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

	function automatic logic [3:0] round_g(input logic [5:0] r);
		logic [3:0] ri;
		logic [3:0] g;
		ri = r[3:0];
		case (r[5:4])
			2'd0: g = ri;
			2'd1: g = 4'(ri * 4'd5 + 4'd1);
			2'd2: g = 4'(ri * 4'd3 + 4'd5);
			2'd3: g = 4'(ri * 4'd7);
			default: g = ri;
		endcase
		return g;
	endfunction

endpackage

// ===== hw/rtl/md5de_msgbuf.sv =====
// MD5 digest engine block buffer: 16 little-endian words, byte writes.
// Depends on md5de_pkg.
module md5de_msgbuf import md5de_pkg::*; (
	input  logic        clk,
	input  logic        we,
	input  logic [5:0]  waddr,
	input  logic [7:0]  wdata,
	input  logic [3:0]  raddr,
	output logic [31:0] rdata
);

	logic [3:0][7:0] mem_q [16];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr[5:2]][waddr[1:0]] <= wdata;
		end
	end

	assign rdata = mem_q[raddr];

endmodule

// ===== hw/rtl/md5de_round.sv =====
// MD5 digest engine shared round unit: message-word index, pre-sum, round
// function, rotate and add. Depends on md5de_pkg.
module md5de_round import md5de_pkg::*; (
	input  md5de_work_t wk,
	input  logic [5:0]  rnd,
	input  logic [31:0] m_word,
	input  logic [31:0] pre,
	output logic [3:0]  g_idx,
	output logic [31:0] pre_nx,
	output logic [31:0] b_nx
);

	logic [31:0] f;
	logic [31:0] sum;
	logic [63:0] dbl;

	always_comb begin
		case (rnd[5:4])
			2'd0: f = wk.d ^ (wk.b & (wk.c ^ wk.d));
			2'd1: f = wk.c ^ (wk.d & (wk.b ^ wk.c));
			2'd2: f = wk.b ^ wk.c ^ wk.d;
			2'd3: f = wk.c ^ (wk.b | ~wk.d);
			default: f = 32'h0;
		endcase
	end

	assign g_idx  = round_g(rnd);
	assign pre_nx = wk.a + round_k(rnd) + m_word;
	assign sum    = pre + f;
	assign dbl    = {sum, sum} << round_s(rnd);
	assign b_nx   = wk.b + dbl[63:32];

endmodule

// ===== hw/rtl/md5_digest_engine_top.sv =====
// MD5 digest engine top level: sequencer, chaining words, bit count.
// Depends on md5de_pkg, md5de_msgbuf, md5de_round.
//
//  channel | direction | payload      | handshake
//  msg     | in        | md5de_in_t   | msg_valid / msg_stall
//  dig     | out       | md5de_out_t  | dig_valid / dig_stall
//
// Plain bytes go to the buffer; the 64th byte of a block starts compression in
// the one round unit (each round registers its pre-sum, then rotates and adds).
// A message end pads one byte per cycle to the block end (64 - position), then
// compresses; a second pad-and-compress pass follows when position >= 56.
// Sixteen digest transactions follow; dig_stall holds them, msg_stall is high
// whenever the engine is not idle. Reset needs no clearing pass.
module md5_digest_engine_top import md5de_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       msg_valid,
	output logic       msg_stall,
	input  md5de_in_t  msg,
	output logic       dig_valid,
	input  logic       dig_stall,
	output md5de_out_t dig
);

	md5de_state_t state_q, state_d;
	logic [5:0]   pos_q;
	logic [63:0]  cnt_q;
	logic [31:0]  chain_q [4];
	md5de_work_t  wk_q;
	logic [31:0]  pre_q;
	logic [5:0]   rnd_q;
	logic         ph_q;
	logic [5:0]   p_q;
	logic         mark_q, extra_q, final_q, end_q;
	logic [3:0]   k_q;

	logic         in_acc, out_acc;
	logic [5:0]   pos_nx;
	logic         buf_we;
	logic [5:0]   buf_waddr;
	logic [7:0]   buf_wdata;
	logic [7:0]   pad_byte;
	logic [3:0]   g_idx;
	logic [31:0]  m_word, pre_nx, b_nx;
	logic [31:0]  out_word;

	assign msg_stall = (state_q != ST_IDLE);
	assign in_acc    = msg_valid && !msg_stall;
	assign dig_valid = (state_q == ST_OUT);
	assign out_acc   = dig_valid && !dig_stall;
	assign pos_nx    = msg.carries_byte ? pos_q + 6'd1 : pos_q;

	always_comb begin
		if (mark_q) begin
			pad_byte = PAD_MARK;
		end else if (!extra_q && p_q[5:3] == 3'b111) begin
			pad_byte = cnt_q[{p_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign buf_we    = (in_acc && msg.carries_byte) || (state_q == ST_PAD);
	assign buf_waddr = (state_q == ST_IDLE) ? pos_q : p_q;
	assign buf_wdata = (state_q == ST_IDLE) ? msg.data_byte : pad_byte;

	md5de_msgbuf u_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (buf_waddr),
		.wdata (buf_wdata),
		.raddr (g_idx),
		.rdata (m_word)
	);

	md5de_round u_round (
		.wk     (wk_q),
		.rnd    (rnd_q),
		.m_word (m_word),
		.pre    (pre_q),
		.g_idx  (g_idx),
		.pre_nx (pre_nx),
		.b_nx   (b_nx)
	);

	assign out_word        = chain_q[k_q[3:2]];
	assign dig.digest_byte = out_word[{k_q[1:0], 3'b000} +: 8];
	assign dig.digest_last = (k_q == LAST_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (msg.carries_byte && pos_q == LAST_POS) begin
						state_d = ST_ROUND;
					end else if (msg.message_end) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (p_q == LAST_POS) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (ph_q && rnd_q == LAST_RND) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (final_q) begin
					state_d = ST_OUT;
				end else if (extra_q || end_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				if (out_acc && k_q == LAST_OUT) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			cnt_q      <= '0;
			chain_q[0] <= INIT_A;
			chain_q[1] <= INIT_B;
			chain_q[2] <= INIT_C;
			chain_q[3] <= INIT_D;
			rnd_q      <= '0;
			ph_q       <= 1'b0;
			p_q        <= '0;
			mark_q     <= 1'b0;
			extra_q    <= 1'b0;
			final_q    <= 1'b0;
			end_q      <= 1'b0;
			k_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (msg.carries_byte) begin
							pos_q <= pos_nx;
							cnt_q <= cnt_q + 64'd8;
						end
						end_q   <= msg.message_end;
						final_q <= 1'b0;
						extra_q <= (state_d == ST_PAD) && (pos_nx[5:3] == 3'b111);
						p_q     <= pos_nx;
						mark_q  <= 1'b1;
					end
				end
				ST_PAD: begin
					mark_q <= 1'b0;
					p_q    <= p_q + 6'd1;
					if (p_q == LAST_POS) begin
						final_q <= !extra_q;
					end
				end
				ST_ROUND: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						rnd_q <= rnd_q + 6'd1;
					end
				end
				ST_FIN: begin
					chain_q[0] <= chain_q[0] + wk_q.a;
					chain_q[1] <= chain_q[1] + wk_q.b;
					chain_q[2] <= chain_q[2] + wk_q.c;
					chain_q[3] <= chain_q[3] + wk_q.d;
					k_q        <= '0;
					p_q        <= '0;
					if (!final_q) begin
						mark_q  <= !extra_q && end_q;
						end_q   <= 1'b0;
						extra_q <= 1'b0;
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						k_q <= k_q + 4'd1;
						if (k_q == LAST_OUT) begin
							chain_q[0] <= INIT_A;
							chain_q[1] <= INIT_B;
							chain_q[2] <= INIT_C;
							chain_q[3] <= INIT_D;
							pos_q      <= '0;
							cnt_q      <= '0;
							final_q    <= 1'b0;
							end_q      <= 1'b0;
						end
					end
				end
				default: ;
			endcase
			if (state_d == ST_ROUND && state_q != ST_ROUND) begin
				rnd_q <= '0;
				ph_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_d == ST_ROUND && state_q != ST_ROUND) begin
			wk_q.a <= chain_q[0];
			wk_q.b <= chain_q[1];
			wk_q.c <= chain_q[2];
			wk_q.d <= chain_q[3];
		end else if (state_q == ST_ROUND) begin
			if (!ph_q) begin
				pre_q <= pre_nx;
			end else begin
				wk_q.a <= wk_q.d;
				wk_q.b <= b_nx;
				wk_q.c <= wk_q.b;
				wk_q.d <= wk_q.c;
			end
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> msg_stall)
		else $error("input accepted while digest pending");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && !dig_stall && dig.digest_last |=> !dig_valid && !msg_stall)
		else $error("digest output did not end after last byte");

	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND && ph_q && rnd_q == LAST_RND |=> state_q == ST_FIN)
		else $error("compression did not finish after final round");

	a_pad_mark: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PAD && mark_q |=> !mark_q)
		else $error("pad marker written more than once");

endmodule
